// ===== hdl/bir_pkg.sv =====
// Shared types and constants for the bilinear image resizer.
package bir_pkg;

  localparam int PIX_W = 16;  // bits per color channel
  localparam int CH_N = 3;    // channels per pixel
  localparam int CFG_W = 9;   // size register width
  localparam int IDX_W = 2;   // register index width
  localparam int STEP_W = 4;  // blend step counter width
  localparam int BLEND_STEPS = 9;  // 3 channels x (top, bottom, vertical)

  typedef logic [PIX_W-1:0] chan_t;
  // index 0 red, 1 green, 2 blue
  typedef chan_t [CH_N-1:0] rgb_t;

  typedef enum logic {
    OP_LOAD,
    OP_EMIT
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_MUL,
    S_LD_WR,
    S_DXS,
    S_DXW,
    S_DYS,
    S_DYW,
    S_MULX,
    S_MULY,
    S_CRDY,
    S_MULA,
    S_BASE,
    S_READ,
    S_BLEND,
    S_DONE
  } state_t;

endpackage

// ===== hdl/bilinear_image_resize.sv =====
// Bilinear image resizer: top level with sequencer and datapath.
//
// Load transfers (op = 0) write source pixels in raster order into a
// single-port image memory; emit transfers (op = 1) return the next
// destination pixel in raster order. A load runs the pixel count multiply,
// then the write, before the next accept. An emit runs two coordinate
// multiplies and the row-base multiply on the shared multiplier, four
// back-to-back reads on the single memory port, then nine blends (three
// per channel) through the same multiplier. The two scale ratios are
// cached; the first emit after any register write also runs the radix-2
// divider twice. A finished pixel waits in the output register while
// further loads are taken.
module bilinear_image_resize import bir_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  // input items
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [PIX_W-1:0] in_red,
  input  logic [PIX_W-1:0] in_green,
  input  logic [PIX_W-1:0] in_blue,
  // result items
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_red,
  output logic [PIX_W-1:0] out_green,
  output logic [PIX_W-1:0] out_blue,
  output logic             last_pixel,
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int CW = (XW > YW) ? XW : YW;        // pixel index width
  localparam int SW = CW + 1;                      // size width
  localparam int FB = FRACTION_BITS;
  localparam int RW = CW + FB;                     // ratio / coordinate width
  localparam int MA_W = (CW + 2 > PIX_W + 1) ? CW + 2 : PIX_W + 1;
  localparam int MB_W = RW;
  localparam int P_W = MA_W + MB_W;
  localparam int IW = P_W - FB;                    // integer part of product
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int CMP_W = (SW > CFG_W) ? SW : CFG_W;
  localparam logic [SW-1:0] MAXW_S = SW'(MAX_WIDTH);
  localparam logic [SW-1:0] MAXH_S = SW'(MAX_HEIGHT);

  state_t state, state_next;

  // registers
  logic [CFG_W-1:0] src_w_raw, src_h_raw, dst_w_raw, dst_h_raw;
  logic [AW-1:0]    load_pos;
  logic [CW-1:0]    col, row;
  logic             ratio_ok;
  logic [RW-1:0]    xr, yr;
  rgb_t             ld_data;
  logic [CW-1:0]    xl, xh, yl, yh;
  logic [FB-1:0]    tx, ty;
  logic [AW-1:0]    base_l, base_h;
  logic [2:0]       rd_cnt;
  rgb_t             pix [4];
  rgb_t             top_v, bot_v, res;
  logic [STEP_W-1:0] step;
  chan_t            dly_a;

  // effective sizes
  logic [SW-1:0] sw, sh, tw, th, sw_m1f, sh_m1f, tw_m1f, th_m1f;
  logic [CW-1:0] sw_m1, sh_m1, tw_m1, th_m1;

  // shared units
  logic signed [MA_W-1:0] mul_a;
  logic [MB_W-1:0]        mul_b;
  logic signed [P_W-1:0]  mul_p;
  logic                   div_start, div_done;
  logic [RW-1:0]          div_num, div_quo;
  logic [CW-1:0]          div_den;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_addr, rd_addr, ld_addr;
  rgb_t          rd_q;

  // load position update
  logic [AW:0]   ld_count, ld_inc;
  logic [AW-1:0] load_pos_next;

  // coordinate split
  logic [CW-1:0] crd_lim, crd_l, crd_h;
  logic [FB-1:0] crd_t;
  logic [IW-1:0] crd_int;
  logic [CW:0]   crd_h1;

  // blend operands and result
  logic [1:0]        bl_ch, wb_ch;
  chan_t             bl_a, bl_b;
  logic [FB-1:0]     bl_t;
  logic signed [PIX_W:0] bl_diff;
  logic [STEP_W-1:0] wb_k;
  logic signed [P_W-1:0] bl_shift, bl_sum;
  chan_t             bl_res;

  logic [SW:0] col_inc, row_inc;
  logic        emit_acc, out_load;

  function automatic logic [SW-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                               input logic [SW-1:0] lim);
    logic [CMP_W-1:0] ve, le;
    ve = CMP_W'(v);
    le = CMP_W'(lim);
    if (v == '0) begin
      return SW'(1);
    end else if (ve > le) begin
      return lim;
    end else begin
      return SW'(v);
    end
  endfunction

  // size clamping
  always_comb begin
    sw = clamp_size(src_w_raw, MAXW_S);
    sh = clamp_size(src_h_raw, MAXH_S);
    tw = clamp_size(dst_w_raw, MAXW_S);
    th = clamp_size(dst_h_raw, MAXH_S);
    sw_m1f = sw - SW'(1);
    sh_m1f = sh - SW'(1);
    tw_m1f = tw - SW'(1);
    th_m1f = th - SW'(1);
    sw_m1 = sw_m1f[CW-1:0];
    sh_m1 = sh_m1f[CW-1:0];
    tw_m1 = tw_m1f[CW-1:0];
    th_m1 = th_m1f[CW-1:0];
  end

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign emit_acc  = in_valid && in_ready && (op_t'(op) == OP_EMIT);
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  bir_div #(.NW(RW), .DW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  bir_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  bir_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (ld_data),
    .rdata (rd_q)
  );

  // load address: count comes from the multiplier
  always_comb begin
    ld_count = mul_p[AW:0];
    ld_addr  = ({1'b0, load_pos} >= ld_count) ? '0 : load_pos;
    ld_inc   = {1'b0, ld_addr} + (AW+1)'(1);
    load_pos_next = (ld_inc >= ld_count) ? '0 : ld_inc[AW-1:0];
  end

  // neighbor read addresses
  always_comb begin
    case (rd_cnt[1:0])
      2'd0:    rd_addr = base_l + AW'(xl);
      2'd1:    rd_addr = base_l + AW'(xh);
      2'd2:    rd_addr = base_h + AW'(xl);
      default: rd_addr = base_h + AW'(xh);
    endcase
    mem_addr = (state == S_LD_WR) ? ld_addr : rd_addr;
  end

  // split coordinate product into integer, fraction and high neighbor
  always_comb begin
    crd_lim = (state == S_MULY) ? sw_m1 : sh_m1;
    crd_int = mul_p[P_W-1:FB];
    if (crd_int > IW'(crd_lim)) begin
      crd_l = crd_lim;
      crd_t = '0;
    end else begin
      crd_l = crd_int[CW-1:0];
      crd_t = mul_p[FB-1:0];
    end
    crd_h1 = {1'b0, crd_l} + ((crd_t != '0) ? (CW+1)'(1) : '0);
    crd_h  = (crd_h1 > {1'b0, crd_lim}) ? crd_lim : crd_h1[CW-1:0];
  end

  // blend operands: steps 0-5 horizontal, 6-8 vertical
  always_comb begin
    bl_ch = '0;
    bl_a  = '0;
    bl_b  = '0;
    bl_t  = tx;
    if (step < STEP_W'(6)) begin
      bl_ch = step[2:1];
      bl_a  = step[0] ? pix[2][bl_ch] : pix[0][bl_ch];
      bl_b  = step[0] ? pix[3][bl_ch] : pix[1][bl_ch];
    end else if (step < STEP_W'(BLEND_STEPS)) begin
      bl_ch = 2'(step - STEP_W'(6));
      bl_a  = top_v[bl_ch];
      bl_b  = bot_v[bl_ch];
      bl_t  = ty;
    end
    bl_diff = $signed({1'b0, bl_b}) - $signed({1'b0, bl_a});
  end

  // blend result: a + floor((b - a) * t / 2^F)
  always_comb begin
    wb_k     = step - STEP_W'(1);
    bl_shift = mul_p >>> FB;
    bl_sum   = bl_shift + $signed({{(P_W-PIX_W){1'b0}}, dly_a});
    bl_res   = bl_sum[PIX_W-1:0];
    if (wb_k < STEP_W'(6)) begin
      wb_ch = wb_k[2:1];
    end else begin
      wb_ch = 2'(wb_k - STEP_W'(6));
    end
  end

  // raster advance
  always_comb begin
    col_inc = {2'b0, col} + (SW+1)'(1);
    row_inc = {2'b0, row} + (SW+1)'(1);
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit operands
  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_start  = 1'b0;
    div_num    = {sw_m1, {FB{1'b0}}};
    div_den    = tw_m1;
    mem_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(op) == OP_EMIT) begin
            state_next = ratio_ok ? S_MULX : S_DXS;
          end else begin
            state_next = S_LD_MUL;
          end
        end
      end
      S_LD_MUL: begin
        mul_a = MA_W'(sw);
        mul_b = MB_W'(sh);
        state_next = S_LD_WR;
      end
      S_LD_WR: begin
        mem_we = 1'b1;
        state_next = S_IDLE;
      end
      S_DXS: begin
        div_start = 1'b1;
        state_next = S_DXW;
      end
      S_DXW: begin
        if (div_done) begin
          state_next = S_DYS;
        end
      end
      S_DYS: begin
        div_start = 1'b1;
        div_num = {sh_m1, {FB{1'b0}}};
        div_den = th_m1;
        state_next = S_DYW;
      end
      S_DYW: begin
        if (div_done) begin
          state_next = S_MULX;
        end
      end
      S_MULX: begin
        mul_a = MA_W'(col);
        mul_b = xr;
        state_next = S_MULY;
      end
      S_MULY: begin
        mul_a = MA_W'(row);
        mul_b = yr;
        state_next = S_CRDY;
      end
      S_CRDY: begin
        state_next = S_MULA;
      end
      S_MULA: begin
        mul_a = MA_W'(yl);
        mul_b = MB_W'(sw);
        state_next = S_BASE;
      end
      S_BASE: begin
        state_next = S_READ;
      end
      S_READ: begin
        if (rd_cnt == 3'd4) begin
          state_next = S_BLEND;
        end
      end
      S_BLEND: begin
        if (step < STEP_W'(BLEND_STEPS)) begin
          mul_a = MA_W'(bl_diff);
          mul_b = MB_W'(bl_t);
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_w_raw <= CFG_W'(1);
      src_h_raw <= CFG_W'(1);
      dst_w_raw <= CFG_W'(1);
      dst_h_raw <= CFG_W'(1);
      ratio_ok  <= 1'b0;
      load_pos  <= '0;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      // register writes invalidate cached ratios
      if (cfg_valid) begin
        ratio_ok <= 1'b0;
        case (reg_idx_t'(cfg_index))
          REG_SRC_W: src_w_raw <= cfg_data;
          REG_SRC_H: src_h_raw <= cfg_data;
          REG_DST_W: dst_w_raw <= cfg_data;
          REG_DST_H: dst_h_raw <= cfg_data;
          default: ;
        endcase
      end else if (state == S_DYW && div_done) begin
        ratio_ok <= 1'b1;
      end
      if (state == S_LD_WR) begin
        load_pos <= load_pos_next;
      end
      // positions past a shrunken size restart at zero
      if (emit_acc) begin
        if ({1'b0, col} >= tw) begin
          col <= '0;
        end
        if ({1'b0, row} >= th) begin
          row <= '0;
        end
      end else if (out_load) begin
        if (col_inc >= (SW+1)'(tw)) begin
          col <= '0;
          row <= (row_inc >= (SW+1)'(th)) ? '0 : row_inc[CW-1:0];
        end else begin
          col <= col_inc[CW-1:0];
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ld_data <= '{in_blue, in_green, in_red};
    end
    if (state == S_DXW && div_done) begin
      xr <= (tw > SW'(1)) ? div_quo : '0;
    end
    if (state == S_DYW && div_done) begin
      yr <= (th > SW'(1)) ? div_quo : '0;
    end
    if (state == S_MULY) begin
      xl <= crd_l;
      xh <= crd_h;
      tx <= crd_t;
    end
    if (state == S_CRDY) begin
      yl <= crd_l;
      yh <= crd_h;
      ty <= crd_t;
    end
    if (state == S_BASE) begin
      base_l <= mul_p[AW-1:0];
      base_h <= mul_p[AW-1:0] + ((yh != yl) ? AW'(sw) : '0);
      rd_cnt <= '0;
      step   <= '0;
    end
    // four reads, data lands in the cycle after its address
    if (state == S_READ) begin
      rd_cnt <= rd_cnt + 3'd1;
      if (rd_cnt != 3'd0) begin
        pix[rd_cnt[1:0] - 2'd1] <= rd_q;
      end
    end
    // blends: issue one per step, write back the previous one
    if (state == S_BLEND) begin
      step  <= step + STEP_W'(1);
      dly_a <= bl_a;
      if (step != '0) begin
        if (wb_k < STEP_W'(6)) begin
          if (wb_k[0]) begin
            bot_v[wb_ch] <= bl_res;
          end else begin
            top_v[wb_ch] <= bl_res;
          end
        end else begin
          res[wb_ch] <= bl_res;
        end
      end
    end
    if (out_load) begin
      out_red    <= res[0];
      out_green  <= res[1];
      out_blue   <= res[2];
      last_pixel <= (col == tw_m1) && (row == th_m1);
    end
  end

endmodule

// ===== hdl/bir_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module bir_div #(
  parameter int NW = 24,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    den_r;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             ge;

  // shift in next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[NW-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: quotient bits replace dividend bits from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

// ===== hdl/bir_mul.sv =====
// Shared signed-by-unsigned multiplier with registered product.
module bir_mul #(
  parameter int A_W = 17,
  parameter int B_W = 24
) (
  input  logic                   clk,
  input  logic signed [A_W-1:0]  a,
  input  logic        [B_W-1:0]  b,
  output logic signed [A_W+B_W-1:0] p
);

  logic signed [A_W+B_W:0] prod;

  // b is zero-extended so the product stays signed
  always_comb begin
    prod = a * $signed({1'b0, b});
  end

  always_ff @(posedge clk) begin
    p <= prod[A_W+B_W-1:0];
  end

endmodule

// ===== hdl/bir_store.sv =====
// Single-port source image memory with registered read.
module bir_store import bir_pkg::*; #(
  parameter int DEPTH = 65536,
  parameter int AW = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  rgb_t          wdata,
  output rgb_t          rdata
);

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
